// File: rtl/bpof_pkg.sv
// Package for the byte pattern occurrence finder.
// Holds the shared sizes, payload structs, configuration codes and helpers.
// It depends on nothing else.
package bpof_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int OFFSET_BITS = 32;
  localparam int LEN_BITS    = $clog2(MAX_PATTERN + 1);
  localparam int CFG_IDX_BITS = 2;

  localparam logic [OFFSET_BITS-1:0] POS_MAX   = {OFFSET_BITS{1'b1}};
  localparam logic [31:0]            COUNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PATTERN_BYTES     = 2'd0,
    CFG_PATTERN_LENGTH    = 2'd1,
    CFG_TARGET_OCCURRENCE = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] occurrence_count;
    logic [31:0] selected_offset;
    logic        patch_allowed;
  } out_word_t;

  // Settings as seen by the datapath: the length is already clamped.
  typedef struct packed {
    logic [63:0]         pattern_bytes;
    logic [LEN_BITS-1:0] length;
    logic [15:0]         target;
  } cfg_t;

  typedef logic [7:0] byte_t;

  // Pattern byte k; bytes past the 64-bit register read as zero.
  function automatic byte_t pattern_byte(logic [63:0] pattern, int k);
    byte_t b;
    b = 8'd0;
    if (k < 8) begin
      b = pattern[8*k +: 8];
    end
    return b;
  endfunction

endpackage

// File: rtl/bpof_cfg.sv
// Configuration registers of the byte pattern occurrence finder.
// Decodes register writes and clamps the pattern length.
// Depends on bpof_pkg.
module bpof_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bpof_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [63:0]                          cfg_data,
  output bpof_pkg::cfg_t                       cfg
);

  logic [63:0] pattern_bytes;
  logic [3:0]  pattern_length;
  logic [15:0] target_occurrence;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes     <= 64'd0;
      pattern_length    <= 4'd1;
      target_occurrence <= 16'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bpof_pkg::cfg_index_t'(cfg_index))
        bpof_pkg::CFG_PATTERN_BYTES:     pattern_bytes     <= cfg_data;
        bpof_pkg::CFG_PATTERN_LENGTH:    pattern_length    <= cfg_data[3:0];
        bpof_pkg::CFG_TARGET_OCCURRENCE: target_occurrence <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // A length of zero acts as one, anything above the window acts as full.
  always_comb begin
    cfg.pattern_bytes = pattern_bytes;
    cfg.target        = target_occurrence;
    if (pattern_length == 4'd0) begin
      cfg.length = bpof_pkg::LEN_BITS'(1);
    end else if (int'(pattern_length) > bpof_pkg::MAX_PATTERN) begin
      cfg.length = bpof_pkg::LEN_BITS'(bpof_pkg::MAX_PATTERN);
    end else begin
      cfg.length = bpof_pkg::LEN_BITS'(pattern_length);
    end
  end

endmodule

// File: rtl/bpof_match.sv
// Masked window compare of the byte pattern occurrence finder.
// Checks the newest bytes of the window against the pattern for the current length.
// Depends on bpof_pkg.
module bpof_match (
  input  bpof_pkg::byte_t window [bpof_pkg::MAX_PATTERN],
  input  bpof_pkg::cfg_t  cfg,
  output logic            hit
);

  logic [bpof_pkg::MAX_PATTERN-1:0] hit_by_len;

  // Entry 0 is the newest byte, so for length L pattern byte k lines up
  // with window entry L-1-k.
  always_comb begin
    for (int l = 1; l <= bpof_pkg::MAX_PATTERN; l++) begin
      hit_by_len[l-1] = 1'b1;
      for (int j = 0; j < l; j++) begin
        if (window[j] != bpof_pkg::pattern_byte(cfg.pattern_bytes, l - 1 - j)) begin
          hit_by_len[l-1] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int l = 1; l <= bpof_pkg::MAX_PATTERN; l++) begin
      if (cfg.length == bpof_pkg::LEN_BITS'(l)) begin
        hit = hit_by_len[l-1];
      end
    end
  end

endmodule

// File: rtl/bpof_out.sv
// Result register of the byte pattern occurrence finder.
// Holds one finished result until the downstream side takes it.
// Depends on bpof_pkg.
module bpof_out (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  bpof_pkg::out_word_t load_word,
  output logic                result_valid,
  input  logic                result_stall,
  output bpof_pkg::out_word_t result_word
);

  logic result_valid_next;

  assign result_valid_next = load || (result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_word <= load_word;
    end
  end

endmodule

// File: rtl/byte_pattern_occurrence_finder.sv
// Top level of the byte pattern occurrence finder.
// Instantiates bpof_cfg, bpof_match and bpof_out; depends on bpof_pkg.

// The block scans a byte stream at one byte per clock and gives one result
// word on the final byte of each stream: the number of pattern occurrences
// (overlapping ones included, counting stops at the target occurrence and
// saturates at its maximum), the start offset of the selected occurrence
// and whether a patch is allowed. A byte passes an input register, then the
// window shift, masked compare and counter update, and a final byte's result
// word is registered in the output register and is valid from there. The sustained
// rate is one byte per cycle; the only stall that reaches the byte side is
// a final byte whose result would overwrite a result that is still held in
// the output register. Configuration writes are taken at any time through
// the write channel, but they must only be issued while no stream is in
// flight. After each result, the window, position, count and offset clear
// for the next stream, while the configuration registers are kept.
module byte_pattern_occurrence_finder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              byte_valid,
  output logic                              byte_stall,
  input  bpof_pkg::in_word_t                byte_word,
  output logic                              result_valid,
  input  logic                              result_stall,
  output bpof_pkg::out_word_t               result_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpof_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [63:0]                       cfg_data
);

  bpof_pkg::cfg_t cfg;

  bpof_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register.
  logic               in_valid;
  bpof_pkg::in_word_t in_word;
  logic               in_valid_next;
  logic               advance;
  logic               accept;

  // Stream state.
  bpof_pkg::byte_t                  window      [bpof_pkg::MAX_PATTERN];
  bpof_pkg::byte_t                  window_next [bpof_pkg::MAX_PATTERN];
  logic [bpof_pkg::OFFSET_BITS-1:0] position;
  logic [bpof_pkg::OFFSET_BITS-1:0] position_next;
  logic [31:0]                      match_count;
  logic [31:0]                      match_count_next;
  logic [bpof_pkg::OFFSET_BITS-1:0] found_offset;
  logic [bpof_pkg::OFFSET_BITS-1:0] found_offset_next;
  logic                             target_reached;
  logic                             target_reached_next;

  logic                             hit;
  logic                             counted;
  logic [bpof_pkg::OFFSET_BITS-1:0] length_wide;
  logic                             load;
  bpof_pkg::out_word_t              load_word;

  // A byte in the input register moves on every cycle unless it is a final
  // byte and the output register is still holding an untaken result.
  assign advance    = in_valid && (!in_word.last_byte || !result_valid || !result_stall);
  assign byte_stall = in_valid && !advance;
  assign accept     = byte_valid && !byte_stall;

  assign in_valid_next = accept || (in_valid && !advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= in_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_word <= byte_word;
    end
  end

  // Shift the new byte into the window; entry 0 holds the newest byte.
  always_comb begin
    window_next[0] = in_word.data_byte;
    for (int i = 1; i < bpof_pkg::MAX_PATTERN; i++) begin
      window_next[i] = window[i-1];
    end
  end

  bpof_match u_match (
    .window (window_next),
    .cfg    (cfg),
    .hit    (hit)
  );

  assign length_wide = bpof_pkg::OFFSET_BITS'(cfg.length);

  // The position saturates, and a match is only looked at once enough
  // bytes have arrived and the target has not yet been reached.
  always_comb begin
    position_next = (position == bpof_pkg::POS_MAX) ? position
                                                    : position + bpof_pkg::OFFSET_BITS'(1);
    counted       = hit && (position_next >= length_wide) && !target_reached;

    match_count_next    = match_count;
    found_offset_next   = found_offset;
    target_reached_next = target_reached;
    if (counted) begin
      if (match_count != bpof_pkg::COUNT_MAX) begin
        match_count_next = match_count + 32'd1;
      end
      found_offset_next = position_next - length_wide;
      if (cfg.target != 16'd0 && match_count_next == 32'(cfg.target)) begin
        target_reached_next = 1'b1;
      end
    end
  end

  // Result for a final byte, built from the updated state.
  always_comb begin
    load_word.occurrence_count = match_count_next;
    load_word.selected_offset  = (match_count_next != 32'd0) ? 32'(found_offset_next) : 32'd0;
    load_word.patch_allowed    = (match_count_next != 32'd0)
                              && (match_count_next == 32'd1
                                  || match_count_next == 32'(cfg.target))
                              && (position_next > length_wide);
  end

  assign load = advance && in_word.last_byte;

  // The stream state clears after a final byte so the next stream starts fresh.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < bpof_pkg::MAX_PATTERN; i++) begin
        window[i] <= 8'd0;
      end
      position       <= '0;
      match_count    <= 32'd0;
      found_offset   <= '0;
      target_reached <= 1'b0;
    end else if (advance) begin
      if (in_word.last_byte) begin
        for (int i = 0; i < bpof_pkg::MAX_PATTERN; i++) begin
          window[i] <= 8'd0;
        end
        position       <= '0;
        match_count    <= 32'd0;
        found_offset   <= '0;
        target_reached <= 1'b0;
      end else begin
        for (int i = 0; i < bpof_pkg::MAX_PATTERN; i++) begin
          window[i] <= window_next[i];
        end
        position       <= position_next;
        match_count    <= match_count_next;
        found_offset   <= found_offset_next;
        target_reached <= target_reached_next;
      end
    end
  end

  bpof_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .load_word    (load_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

endmodule

// File: tb/bpof_scan_checker.sv
// Checker for the byte pattern occurrence finder testbench.
// Watches the byte, result and configuration channels, rescans every stream
// and compares each result word; depends on bpof_pkg.
module bpof_scan_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              byte_valid,
  input  logic                              byte_stall,
  input  bpof_pkg::in_word_t                byte_word,
  input  logic                              result_valid,
  input  logic                              result_stall,
  input  bpof_pkg::out_word_t               result_word,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [bpof_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [63:0]                       cfg_data,
  output int                                pending,
  output int                                error_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the configuration registers.
  logic [63:0] pattern_reg;
  logic [3:0]  length_reg;
  logic [15:0] target_reg;

  // Shadow copy of the per-stream scan state.
  bpof_pkg::byte_t                  window [bpof_pkg::MAX_PATTERN];
  logic [bpof_pkg::OFFSET_BITS-1:0] position;
  logic [bpof_pkg::OFFSET_BITS-1:0] last_start;
  logic [31:0]                      hit_count;
  logic                             target_hit;

  bpof_pkg::out_word_t stream_reports[$];
  int                  errors = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic clear_stream();
    for (int i = 0; i < bpof_pkg::MAX_PATTERN; i++) begin
      window[i] = 8'h00;
    end
    position   = '0;
    last_start = '0;
    hit_count  = '0;
    target_hit = 1'b0;
  endtask

  // Shift one byte into the window, look for a match ending at it, and on
  // the final byte of a stream queue the word the block has to report.
  task automatic scan_byte(input bpof_pkg::in_word_t w);
    int                  n;
    int                  k;
    logic                match;
    bpof_pkg::byte_t     want_byte;
    bpof_pkg::out_word_t rep;
    if (length_reg == 4'd0) begin
      n = 1;
    end else if (length_reg > bpof_pkg::MAX_PATTERN) begin
      n = bpof_pkg::MAX_PATTERN;
    end else begin
      n = int'(length_reg);
    end
    for (k = bpof_pkg::MAX_PATTERN - 1; k > 0; k--) begin
      window[k] = window[k-1];
    end
    window[0] = w.data_byte;
    if (position != bpof_pkg::POS_MAX) begin
      position = position + bpof_pkg::OFFSET_BITS'(1);
    end
    if (position >= n && !target_hit) begin
      match = 1'b1;
      for (k = 0; k < n; k++) begin
        want_byte = (k < 8) ? pattern_reg[8*k +: 8] : 8'h00;
        if (window[n-1-k] != want_byte) begin
          match = 1'b0;
        end
      end
      if (match) begin
        if (hit_count != bpof_pkg::COUNT_MAX) begin
          hit_count = hit_count + 32'd1;
        end
        last_start = position - bpof_pkg::OFFSET_BITS'(n);
        if (target_reg != 16'd0 && hit_count == {16'd0, target_reg}) begin
          target_hit = 1'b1;
        end
      end
    end
    if (w.last_byte) begin
      rep.occurrence_count = hit_count;
      rep.selected_offset  = (hit_count != 0) ? last_start[31:0] : 32'd0;
      rep.patch_allowed    = (hit_count != 0) &&
                             (hit_count == 1 || hit_count == {16'd0, target_reg}) &&
                             (position > n);
      stream_reports.push_back(rep);
      clear_stream();
    end
  endtask

  task automatic check_result(input bpof_pkg::out_word_t got);
    bpof_pkg::out_word_t want;
    if (stream_reports.size() == 0) begin
      report_mismatch($sformatf("unexpected result word: count %0d offset %0d patch %0b",
                                got.occurrence_count, got.selected_offset,
                                got.patch_allowed));
    end else begin
      want = stream_reports.pop_front();
      if (got.occurrence_count !== want.occurrence_count) begin
        report_mismatch($sformatf("occurrence_count %0d, expected %0d",
                                  got.occurrence_count, want.occurrence_count));
      end
      if (got.selected_offset !== want.selected_offset) begin
        report_mismatch($sformatf("selected_offset %0d, expected %0d",
                                  got.selected_offset, want.selected_offset));
      end
      if (got.patch_allowed !== want.patch_allowed) begin
        report_mismatch($sformatf("patch_allowed %0b, expected %0b",
                                  got.patch_allowed, want.patch_allowed));
      end
    end
  endtask

  // A result can never leave in the cycle its final byte enters, so the
  // result side is checked before the byte side at each edge.
  always @(posedge clk) begin
    if (rst) begin
      pattern_reg = 64'd0;
      length_reg  = 4'd1;
      target_reg  = 16'd0;
      clear_stream();
      stream_reports.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bpof_pkg::CFG_PATTERN_BYTES:     pattern_reg = cfg_data;
          bpof_pkg::CFG_PATTERN_LENGTH:    length_reg  = cfg_data[3:0];
          bpof_pkg::CFG_TARGET_OCCURRENCE: target_reg  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        check_result(result_word);
      end
      if (byte_valid && !byte_stall) begin
        scan_byte(byte_word);
      end
    end
    pending     <= stream_reports.size();
    error_count <= errors;
  end

endmodule

// File: tb/byte_pattern_occurrence_finder_tb.sv
// Top of the byte pattern occurrence finder testbench: clock, reset, stimulus
// and verdict. Depends on bpof_pkg, the block itself and bpof_scan_checker.
module byte_pattern_occurrence_finder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS          = 500;
  localparam int NUM_PHASES     = 10;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 16;
  localparam int WATCHDOG_LIMIT = 2000;

  // Index 3 names no register; the block has to ignore writes to it.
  localparam logic [bpof_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_INDEX = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                              byte_valid   = 1'b0;
  logic                              byte_stall;
  bpof_pkg::in_word_t                byte_word    = '0;
  logic                              result_valid;
  logic                              result_stall = 1'b0;
  bpof_pkg::out_word_t               result_word;
  logic                              cfg_valid    = 1'b0;
  logic                              cfg_ready;
  logic [bpof_pkg::CFG_IDX_BITS-1:0] cfg_index    = '0;
  logic [63:0]                       cfg_data     = '0;

  int pending;
  int error_count;

  // Sender burst state and the receiver's stall pattern.
  int burst_left = 0;
  int stall_left = 0;
  int stall_mode = 0;
  int idle_cycles;

  // What the stimulus knows of the current settings, so that it can build
  // streams that actually contain the pattern.
  logic [63:0] pattern_shadow;
  int          span_shadow;

  bpof_pkg::byte_t stream_bytes[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  byte_pattern_occurrence_finder i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_word    (byte_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  bpof_scan_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_word    (byte_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pending      (pending),
    .error_count  (error_count)
  );

  // The receiver cycles through segments of its own: free running, random
  // stalls, a solid stall, and a toggling stall. The solid stalls back the
  // held result word up into the byte side.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        case (stall_mode)
          0:       stall_left = $urandom_range(10, 60);
          1:       stall_left = $urandom_range(20, 60);
          2:       stall_left = $urandom_range(1, 30);
          default: stall_left = $urandom_range(4, 20);
        endcase
      end
      stall_left--;
      case (stall_mode)
        0:       result_stall <= 1'b0;
        1:       result_stall <= ($urandom_range(0, 1) == 1);
        2:       result_stall <= 1'b1;
        default: result_stall <= ~result_stall;
      endcase
    end
  end

  // The watchdog ends the run when no word moves on any channel for too
  // long. Every legal stretch without a handshake is far shorter.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("byte_pattern_occurrence_finder verification failed");
    $finish;
  end

  // Present one register write and hold it until the block takes it. The
  // valid stays high so that writes can follow back to back; the caller
  // lowers it after the last one.
  task automatic write_reg(input logic [bpof_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write all three registers. Only the low bits of the length and target
  // registers are meant to count, so the bits above them are random or zero.
  task automatic load_settings(input logic [63:0] pat, input logic [3:0] len_raw,
                               input logic [15:0] tgt);
    logic [63:0] filler;
    write_reg(bpof_pkg::CFG_PATTERN_BYTES, pat);
    filler = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : 64'd0;
    write_reg(bpof_pkg::CFG_PATTERN_LENGTH, {filler[63:4], len_raw});
    filler = ($urandom_range(0, 1) == 1) ? {$urandom, $urandom} : 64'd0;
    write_reg(bpof_pkg::CFG_TARGET_OCCURRENCE, {filler[63:16], tgt});
    if ($urandom_range(0, 3) == 0) begin
      write_reg(CFG_SPARE_INDEX, {$urandom, $urandom});
    end
    cfg_valid <= 1'b0;
    pattern_shadow = pat;
    if (len_raw == 4'd0) begin
      span_shadow = 1;
    end else if (len_raw > bpof_pkg::MAX_PATTERN) begin
      span_shadow = bpof_pkg::MAX_PATTERN;
    end else begin
      span_shadow = int'(len_raw);
    end
  endtask

  // Present one byte and hold it until it is accepted. The sender works in
  // bursts; between bursts it usually drops valid, so the gaps land anywhere
  // inside a stream, including just before its last byte.
  task automatic send_byte(input bpof_pkg::byte_t b, input logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        byte_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    byte_valid <= 1'b1;
    byte_word  <= '{data_byte: b, last_byte: last};
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  // Send the bytes in stream_bytes as one stream, the last one marked.
  task automatic send_stream();
    for (int i = 0; i < stream_bytes.size(); i++) begin
      send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    end
  endtask

  // Let every outstanding result word come out, then let the pipeline settle
  // before the settings change or the run ends.
  task automatic drain();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int              phase;
    int              phase_bytes;
    int              stream_len;
    int              pick;
    int              flip_at;
    bpof_pkg::byte_t b0;
    bpof_pkg::byte_t b1;
    logic [63:0]     pat;
    logic [3:0]      len_raw;
    logic [15:0]     tgt;

    pattern_shadow = 64'd0;
    span_shadow    = 1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part. The settings right after reset are used first: a
    // pattern of one zero byte, so a one-byte stream matches at its final
    // byte but is not longer than the pattern, and the next one is.
    stream_bytes = '{8'h00};
    send_stream();
    stream_bytes = '{8'hFF, 8'h00};
    send_stream();

    // Overlapping matches of a self-similar pattern, with no target, then
    // with the target reached on the last match, then reached early so that
    // counting stops. The last pattern write has set bits above its low two bytes.
    drain();
    load_settings(64'h0000_0000_0000_AAAA, 4'd2, 16'd0);
    stream_bytes = '{8'hAA, 8'hAA, 8'hAA};
    send_stream();
    drain();
    load_settings(64'h0000_0000_0000_AAAA, 4'd2, 16'd2);
    stream_bytes = '{8'hAA, 8'hAA, 8'hAA};
    send_stream();
    drain();
    load_settings(64'hFFFF_FFFF_FFFF_AAAA, 4'd2, 16'd1);
    stream_bytes = '{8'hAA, 8'hAA, 8'hAA, 8'hAA};
    send_stream();

    // A length above the window acts as the full window; the target is
    // beyond reach, so the only match found is the one reported.
    drain();
    load_settings(64'h80FF_0001_7F55_AAFE, 4'd15, 16'hFFFF);
    stream_bytes = '{8'hFE, 8'hAA, 8'h55, 8'h7F, 8'h01, 8'h00, 8'hFF, 8'h80};
    send_stream();

    // A length of zero acts as one: only pattern byte 0 is compared.
    drain();
    load_settings(64'h80FF_0001_7F55_AAFE, 4'd0, 16'd0);
    stream_bytes = '{8'h00, 8'hFE};
    send_stream();

    // Random part. Each phase has its own settings, and the extremes of the
    // length come first. Most streams are built from copies of the pattern
    // and its bytes, so matches, overlaps and targets are hit often; the
    // rest is noise and copies with one byte broken.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      pick = $urandom_range(0, 3);
      b0   = bpof_pkg::byte_t'($urandom);
      b1   = bpof_pkg::byte_t'($urandom);
      case (pick)
        0:       pat = {8{b0}};
        1:       pat = {4{b1, b0}};
        default: pat = {$urandom, $urandom};
      endcase
      if (phase == 0) begin
        len_raw = 4'd8;
      end else if (phase == 1) begin
        len_raw = 4'd1;
      end else if (phase == 2) begin
        len_raw = 4'd15;
      end else if (phase % 3 == 0) begin
        len_raw = 4'($urandom_range(0, 15));
      end else begin
        len_raw = 4'($urandom_range(1, 4));
      end
      case ($urandom_range(0, 5))
        0:       tgt = 16'd0;
        1:       tgt = 16'd1;
        2:       tgt = 16'd2;
        3:       tgt = 16'($urandom_range(3, 6));
        4:       tgt = 16'hFFFF;
        default: tgt = 16'($urandom_range(0, 65535));
      endcase
      drain();
      load_settings(pat, len_raw, tgt);

      phase_bytes = 0;
      while (phase_bytes < ITEMS / NUM_PHASES) begin
        stream_len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40)
                                                 : $urandom_range(1, 16);
        stream_bytes.delete();
        while (stream_bytes.size() < stream_len) begin
          pick = $urandom_range(0, 9);
          if (pick < 4) begin
            for (int k = 0; k < span_shadow; k++) begin
              stream_bytes.push_back(pattern_shadow[8*k +: 8]);
            end
          end else if (pick < 7) begin
            stream_bytes.push_back(pattern_shadow[8*$urandom_range(0, span_shadow - 1) +: 8]);
          end else if (pick < 9) begin
            stream_bytes.push_back(bpof_pkg::byte_t'($urandom));
          end else begin
            flip_at = $urandom_range(0, span_shadow - 1);
            for (int k = 0; k < span_shadow; k++) begin
              b0 = pattern_shadow[8*k +: 8];
              if (k == flip_at) begin
                b0 = b0 ^ bpof_pkg::byte_t'($urandom_range(1, 255));
              end
              stream_bytes.push_back(b0);
            end
          end
        end
        while (stream_bytes.size() > stream_len) begin
          void'(stream_bytes.pop_back());
        end
        send_stream();
        phase_bytes += stream_len;
      end
    end

    drain();
    repeat (END_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("byte_pattern_occurrence_finder verification clean");
    end else begin
      $display("byte_pattern_occurrence_finder verification failed");
    end
    $finish;
  end

endmodule
